// ===== rtl/kmp_pkg.sv =====
package kmp_pkg;

   localparam int MAX_PATTERN = 256;
   localparam int IDX_W       = $clog2(MAX_PATTERN);
   localparam int LEN_W       = IDX_W + 1;
   localparam int POS_W       = 32;
   localparam int START_W     = 32;

   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_TEXT    = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] symbol;
      logic       first;
   } kmp_req_type;

   typedef struct packed {
      logic               match_found;
      logic [START_W-1:0] match_start;
      logic               pattern_overflow;
   } kmp_rsp_type;

   typedef struct packed {
      logic             pat_we;
      logic [IDX_W-1:0] pat_waddr;
      logic [7:0]       pat_wdata;
      logic             fail_we;
      logic [IDX_W-1:0] fail_waddr;
      logic [IDX_W-1:0] fail_wdata;
      logic [IDX_W-1:0] pat_raddr;
      logic [IDX_W-1:0] fail_raddr;
   } kmp_mem_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_TAIL_READ,
      ST_TAIL_WAIT
   } kmp_state_type;

endpackage

// ===== rtl/kmp_store.sv =====
module kmp_store (
   input  logic                          clock,
   input  kmp_pkg::kmp_mem_ctl_type      mem_ctl,
   output logic [7:0]                    pat_rdata,
   output logic [kmp_pkg::IDX_W-1:0]     fail_rdata
);

   logic [7:0]                pattern_mem [kmp_pkg::MAX_PATTERN];
   logic [kmp_pkg::IDX_W-1:0] failure_mem [kmp_pkg::MAX_PATTERN];

   always_ff @(posedge clock) begin
      if (mem_ctl.pat_we) begin
         pattern_mem[mem_ctl.pat_waddr] <= mem_ctl.pat_wdata;
      end
      pat_rdata <= pattern_mem[mem_ctl.pat_raddr];
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.fail_we) begin
         failure_mem[mem_ctl.fail_waddr] <= mem_ctl.fail_wdata;
      end
      fail_rdata <= failure_mem[mem_ctl.fail_raddr];
   end

endmodule

// ===== rtl/kmp_seq.sv =====
module kmp_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  kmp_pkg::kmp_req_type          req_item,
   output logic                          rsp_strobe,
   output kmp_pkg::kmp_rsp_type          rsp_item,
   output kmp_pkg::kmp_mem_ctl_type      mem_ctl,
   input  logic [7:0]                    pat_rdata,
   input  logic [kmp_pkg::IDX_W-1:0]     fail_rdata
);

   kmp_pkg::kmp_state_type    state_ff, state_in;
   logic                      kind_ff, kind_in;
   logic [7:0]                sym_ff, sym_in;
   logic [kmp_pkg::IDX_W-1:0] pos_ff, pos_in;
   logic [kmp_pkg::LEN_W-1:0] j_ff, j_in;
   logic [kmp_pkg::LEN_W-1:0] plen_ff, plen_in;
   logic [kmp_pkg::IDX_W-1:0] blen_ff, blen_in;
   logic [kmp_pkg::LEN_W-1:0] mcount_ff, mcount_in;
   logic [kmp_pkg::POS_W-1:0] tidx_ff, tidx_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   kmp_pkg::kmp_rsp_type      rsp_ff, rsp_in;

   logic                      accept;
   logic [kmp_pkg::LEN_W-1:0] eff_plen;
   logic [kmp_pkg::LEN_W-1:0] eff_mc;
   logic [kmp_pkg::LEN_W-1:0] j_m1;
   logic [kmp_pkg::LEN_W-1:0] j_next;
   logic                      sym_eq;
   logic [kmp_pkg::POS_W-1:0] start_pos;

   assign accept     = start && (state_ff == kmp_pkg::ST_IDLE);
   assign busy       = (state_ff != kmp_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // shared compare unit: one symbol compare per walk step
   assign sym_eq = (sym_ff == pat_rdata);
   assign j_m1   = j_ff - kmp_pkg::LEN_W'(1);
   assign j_next = sym_eq ? (j_ff + kmp_pkg::LEN_W'(1)) : j_ff;
   assign start_pos = tidx_ff - kmp_pkg::POS_W'(plen_ff);

   assign eff_plen = req_item.first ? '0 : plen_ff;
   assign eff_mc   = req_item.first ? '0 : mcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kmp_pkg::ST_IDLE;
         plen_ff       <= '0;
         blen_ff       <= '0;
         mcount_ff     <= '0;
         tidx_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         plen_ff       <= plen_in;
         blen_ff       <= blen_in;
         mcount_ff     <= mcount_in;
         tidx_ff       <= tidx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      sym_ff  <= sym_in;
      pos_ff  <= pos_in;
      j_ff    <= j_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      sym_in        = sym_ff;
      pos_in        = pos_ff;
      j_in          = j_ff;
      plen_in       = plen_ff;
      blen_in       = blen_ff;
      mcount_in     = mcount_ff;
      tidx_in       = tidx_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      mem_ctl            = '0;
      mem_ctl.pat_raddr  = j_ff[kmp_pkg::IDX_W-1:0];
      mem_ctl.fail_raddr = j_m1[kmp_pkg::IDX_W-1:0];

      unique case (state_ff)
         kmp_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in = req_item.kind;
               sym_in  = req_item.symbol;
               rsp_in  = '0;
               if (req_item.kind == kmp_pkg::KIND_PATTERN) begin
                  if (req_item.first) begin
                     plen_in   = '0;
                     blen_in   = '0;
                     mcount_in = '0;
                  end
                  if (eff_plen == kmp_pkg::LEN_W'(kmp_pkg::MAX_PATTERN)) begin
                     rsp_in.pattern_overflow = 1'b1;
                     rsp_strobe_in           = 1'b1;
                  end else begin
                     mem_ctl.pat_we    = 1'b1;
                     mem_ctl.pat_waddr = eff_plen[kmp_pkg::IDX_W-1:0];
                     mem_ctl.pat_wdata = req_item.symbol;
                     pos_in            = eff_plen[kmp_pkg::IDX_W-1:0];
                     if (eff_plen == '0) begin
                        // first pattern byte has an empty prefix-suffix
                        mem_ctl.fail_we    = 1'b1;
                        mem_ctl.fail_waddr = '0;
                        mem_ctl.fail_wdata = '0;
                        blen_in            = '0;
                        plen_in            = kmp_pkg::LEN_W'(1);
                        rsp_strobe_in      = 1'b1;
                     end else begin
                        j_in     = {1'b0, blen_ff};
                        state_in = kmp_pkg::ST_READ;
                     end
                  end
               end else begin
                  mcount_in = eff_mc;
                  // tidx holds the index of the next text byte from here on
                  tidx_in   = (req_item.first ? '0 : tidx_ff) + kmp_pkg::POS_W'(1);
                  if (plen_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                  end else begin
                     j_in     = (eff_mc >= plen_ff) ? '0 : eff_mc;
                     state_in = kmp_pkg::ST_READ;
                  end
               end
            end
         end
         kmp_pkg::ST_READ: begin
            state_in = kmp_pkg::ST_CMP;
         end
         kmp_pkg::ST_CMP: begin
            if (j_ff != '0 && !sym_eq) begin
               // fall back through the failure table
               j_in     = {1'b0, fail_rdata};
               state_in = kmp_pkg::ST_READ;
            end else if (kind_ff == kmp_pkg::KIND_PATTERN) begin
               mem_ctl.fail_we    = 1'b1;
               mem_ctl.fail_waddr = pos_ff;
               mem_ctl.fail_wdata = j_next[kmp_pkg::IDX_W-1:0];
               blen_in            = j_next[kmp_pkg::IDX_W-1:0];
               plen_in            = {1'b0, pos_ff} + kmp_pkg::LEN_W'(1);
               rsp_strobe_in      = 1'b1;
               state_in           = kmp_pkg::ST_IDLE;
            end else if (j_next == plen_ff) begin
               j_in     = j_next;
               state_in = kmp_pkg::ST_TAIL_READ;
            end else begin
               mcount_in     = j_next;
               rsp_strobe_in = 1'b1;
               state_in      = kmp_pkg::ST_IDLE;
            end
         end
         kmp_pkg::ST_TAIL_READ: begin
            state_in = kmp_pkg::ST_TAIL_WAIT;
         end
         kmp_pkg::ST_TAIL_WAIT: begin
            // full match: keep the border so overlapping matches are found
            mcount_in          = {1'b0, fail_rdata};
            rsp_in.match_found = 1'b1;
            rsp_in.match_start = kmp_pkg::START_W'(start_pos);
            rsp_strobe_in      = 1'b1;
            state_in           = kmp_pkg::ST_IDLE;
         end
         default: begin
            state_in = kmp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/kmp_pattern_matcher_unit.sv =====
// channel   ports                         handshake
// request   start, busy, req_item         taken when start is high and busy is low
// response  rsp_strobe, rsp_item          one cycle per result, cannot be held off
//
// a transaction that needs no table walk (first or dropped pattern byte, text with an
// empty pattern) returns its result in the next cycle without going busy
// otherwise busy lasts 2 cycles per pattern-store lookup (read, compare) through the
// registered-read pattern and failure memories: 2 + 2*fallbacks, plus 2 on a full match
// reset is synchronous and clears the pattern length, match and text position state
// the response is registered, so a new request may be taken while it is shown
module kmp_pattern_matcher_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  kmp_pkg::kmp_req_type req_item,
   output logic                 rsp_strobe,
   output kmp_pkg::kmp_rsp_type rsp_item
);

   kmp_pkg::kmp_mem_ctl_type  mem_ctl;
   logic [7:0]                pat_rdata;
   logic [kmp_pkg::IDX_W-1:0] fail_rdata;

   kmp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .mem_ctl    (mem_ctl),
      .pat_rdata  (pat_rdata),
      .fail_rdata (fail_rdata)
   );

   kmp_store u_store (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .pat_rdata  (pat_rdata),
      .fail_rdata (fail_rdata)
   );

endmodule

// ===== rtl/kmp_checker.sv =====
module kmp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input kmp_pkg::kmp_req_type req_item,
   input logic                 rsp_strobe,
   input kmp_pkg::kmp_rsp_type rsp_item
);

   // every accepted transaction either keeps the unit busy or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted transaction neither busy nor answered");

   // finishing a walk always produces a result
   a_done_response: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("busy dropped without a result");

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_item.match_found && rsp_item.pattern_overflow))
      else $error("match and overflow in one result");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.match_found) |-> (rsp_item.match_start == '0))
      else $error("start position without a match");

endmodule

bind kmp_pattern_matcher_unit kmp_checker u_kmp_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

// ===== test/tb_top.sv =====
module tb_top;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int TAIL_CYCLES  = 20;
   localparam int RANDOM_ITEMS = 450;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   kmp_pkg::kmp_req_type req_item = '0;
   logic                 rsp_strobe;
   kmp_pkg::kmp_rsp_type rsp_item;

   kmp_pattern_matcher_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #5 clock = ~clock;

   // matcher state mirrored by the testbench
   logic [7:0]  pat_bytes [kmp_pkg::MAX_PATTERN];
   int unsigned fail_len [kmp_pkg::MAX_PATTERN];
   int unsigned pat_len, build_len, matched;
   logic [31:0] text_pos;

   kmp_pkg::kmp_rsp_type awaited_reports [$];
   kmp_pkg::kmp_rsp_type want;
   int          error_count, item_count, match_total, drop_total, longest_pattern;
   int          max_gap;
   longint      cycle_count;

   function automatic kmp_pkg::kmp_rsp_type advance_matcher(kmp_pkg::kmp_req_type item);
      kmp_pkg::kmp_rsp_type r;
      int unsigned pos, len, j;
      r = '0;
      if (item.kind == kmp_pkg::KIND_PATTERN) begin
         if (item.first) begin
            pat_len   = 0;
            build_len = 0;
            matched   = 0;
         end
         if (pat_len >= kmp_pkg::MAX_PATTERN) begin
            r.pattern_overflow = 1'b1;
         end else begin
            pos = pat_len;
            len = build_len;
            pat_bytes[pos] = item.symbol;
            if (pos == 0) begin
               len = 0;
            end else begin
               while (len > 0 && item.symbol != pat_bytes[len])
                  len = fail_len[len-1];
               if (item.symbol == pat_bytes[len])
                  len++;
            end
            fail_len[pos] = len;
            build_len     = len;
            pat_len       = pos + 1;
         end
      end else begin
         if (item.first) begin
            text_pos = '0;
            matched  = 0;
         end
         if (pat_len > 0) begin
            j = matched;
            if (j >= pat_len)
               j = 0;
            while (j > 0 && item.symbol != pat_bytes[j])
               j = fail_len[j-1];
            if (item.symbol == pat_bytes[j])
               j++;
            if (j == pat_len) begin
               r.match_found = 1'b1;
               r.match_start = text_pos + 32'd1 - pat_len;
               j = fail_len[j-1];
            end
            matched = j;
         end
         text_pos = text_pos + 32'd1;
      end
      return r;
   endfunction

   // called just after a falling edge, returns just after a falling edge
   task automatic send_byte(logic kind, logic [7:0] symbol, logic first);
      kmp_pkg::kmp_req_type item;
      kmp_pkg::kmp_rsp_type expected;
      int gap;
      item.kind   = kind;
      item.symbol = symbol;
      item.first  = first;
      req_item <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      expected        = advance_matcher(item);
      awaited_reports = {awaited_reports, expected};
      item_count++;
      if (kind == kmp_pkg::KIND_PATTERN && pat_len > longest_pattern)
         longest_pattern = pat_len;
      @(negedge clock);
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_all_reported();
      start <= 1'b0;
      while (awaited_reports.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (awaited_reports.size() == 0) begin
            $error("result with no transaction outstanding");
            error_count++;
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_item.match_found !== want.match_found) begin
               $error("match_found expected %0d actual %0d",
                      want.match_found, rsp_item.match_found);
               error_count++;
            end
            if (rsp_item.match_start !== want.match_start) begin
               $error("match_start expected %0d actual %0d",
                      want.match_start, rsp_item.match_start);
               error_count++;
            end
            if (rsp_item.pattern_overflow !== want.pattern_overflow) begin
               $error("pattern_overflow expected %0d actual %0d",
                      want.pattern_overflow, rsp_item.pattern_overflow);
               error_count++;
            end
            if (want.match_found)
               match_total++;
            if (want.pattern_overflow)
               drop_total++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic test_empty_pattern();
      max_gap = 0;
      send_byte(kmp_pkg::KIND_TEXT, 8'h00, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'hff, 1'b1);
      send_byte(kmp_pkg::KIND_TEXT, 8'h41, 1'b0);
      wait_all_reported();
   endtask

   task automatic test_overlapping_matches();
      max_gap = 10;
      send_byte(kmp_pkg::KIND_PATTERN, 8'h61, 1'b1);
      send_byte(kmp_pkg::KIND_PATTERN, 8'h62, 1'b0);
      send_byte(kmp_pkg::KIND_PATTERN, 8'h61, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'h61, 1'b1);
      send_byte(kmp_pkg::KIND_TEXT, 8'h62, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'h61, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'h62, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'h61, 1'b0);
      // text restart in the middle of a partial match
      send_byte(kmp_pkg::KIND_TEXT, 8'h62, 1'b1);
      wait_all_reported();
   endtask

   task automatic test_extreme_symbols();
      max_gap = 3;
      send_byte(kmp_pkg::KIND_PATTERN, 8'hff, 1'b1);
      send_byte(kmp_pkg::KIND_PATTERN, 8'h00, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'h00, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'hff, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'h00, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'hff, 1'b0);
      wait_all_reported();
   endtask

   task automatic test_pattern_grown_mid_scan();
      max_gap = 10;
      send_byte(kmp_pkg::KIND_PATTERN, 8'h61, 1'b1);
      send_byte(kmp_pkg::KIND_PATTERN, 8'h62, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'h61, 1'b1);
      // partial match of one byte must survive the append
      send_byte(kmp_pkg::KIND_PATTERN, 8'h63, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'h62, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'h63, 1'b0);
      wait_all_reported();
   endtask

   task automatic test_full_store();
      max_gap = 2;
      send_byte(kmp_pkg::KIND_PATTERN, 8'h5a, 1'b1);
      repeat (kmp_pkg::MAX_PATTERN - 1) send_byte(kmp_pkg::KIND_PATTERN, 8'h5a, 1'b0);
      send_byte(kmp_pkg::KIND_PATTERN, 8'h5a, 1'b0);
      send_byte(kmp_pkg::KIND_PATTERN, 8'h00, 1'b0);
      send_byte(kmp_pkg::KIND_TEXT, 8'h5a, 1'b1);
      repeat (kmp_pkg::MAX_PATTERN + 3) send_byte(kmp_pkg::KIND_TEXT, 8'h5a, 1'b0);
      // mismatch right after a full match walks the whole failure chain
      send_byte(kmp_pkg::KIND_TEXT, 8'ha5, 1'b0);
      repeat (4) send_byte(kmp_pkg::KIND_TEXT, 8'h5a, 1'b0);
      wait_all_reported();
   endtask

   task automatic test_random_streams();
      logic [7:0] base, sym;
      int         alpha, plen, tlen, roll, target;
      target = item_count + RANDOM_ITEMS;
      while (item_count < target) begin
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
         base    = 8'($urandom_range(0, 255));
         alpha   = $urandom_range(1, 3);
         plen    = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
         for (int i = 0; i < plen; i++) begin
            sym = base + 8'($urandom_range(0, alpha - 1));
            send_byte(kmp_pkg::KIND_PATTERN, sym, (i == 0) && ($urandom_range(0, 7) != 0));
         end
         tlen = $urandom_range(10, 50);
         for (int i = 0; i < tlen; i++) begin
            roll = $urandom_range(0, 119);
            sym  = base + 8'($urandom_range(0, alpha - 1));
            if (roll < 12)
               send_byte(kmp_pkg::KIND_TEXT, 8'($urandom_range(0, 255)), 1'b0);
            else if (roll < 16)
               send_byte(kmp_pkg::KIND_TEXT, sym, 1'b1);
            else if (roll < 19)
               send_byte(kmp_pkg::KIND_PATTERN, sym, 1'b0);
            else if (roll < 20)
               send_byte(kmp_pkg::KIND_PATTERN, sym, 1'b1);
            else
               send_byte(kmp_pkg::KIND_TEXT, sym, (i == 0) && ($urandom_range(0, 3) != 0));
         end
         if ($urandom_range(0, 9) == 0)
            wait_all_reported();
      end
      wait_all_reported();
   endtask

   initial begin
      for (int i = 0; i < kmp_pkg::MAX_PATTERN; i++) begin
         pat_bytes[i] = '0;
         fail_len[i]  = 0;
      end
      pat_len   = 0;
      build_len = 0;
      matched   = 0;
      text_pos  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_pattern();
      test_overlapping_matches();
      test_extreme_symbols();
      test_pattern_grown_mid_scan();
      test_full_store();
      test_random_streams();

      $display("covered %0d transactions with %0d matches and %0d dropped pattern bytes",
               item_count, match_total, drop_total);
      $display("patterns up to %0d bytes, restarts and appends in mid-scan, random stalls",
               longest_pattern);
      if (error_count == 0 && awaited_reports.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== kmp_pattern_matcher_unit.f =====
rtl/kmp_pkg.sv
rtl/kmp_store.sv
rtl/kmp_seq.sv
rtl/kmp_pattern_matcher_unit.sv
rtl/kmp_checker.sv
test/tb_top.sv
